[sv/vtae_pkg.sv]
// Shared types, constants and helpers for the vector terminal address encoder.
// No dependencies; every other file in sv/ refers to this package by scope.
`timescale 1ns / 1ps

package vtae_pkg;

  localparam int MAX_BYTES   = 6;
  localparam int BYTE_W      = 7;
  localparam int IDX_W       = $clog2(MAX_BYTES);
  localparam int QUEUE_DEPTH = 2;

  localparam logic [BYTE_W-1:0] BYTE_GS  = 7'o035;
  localparam logic [BYTE_W-1:0] TAG_HIGH = 7'o040;
  localparam logic [BYTE_W-1:0] TAG_LOWY = 7'o140;
  localparam logic [BYTE_W-1:0] TAG_LOWX = 7'o100;

  localparam logic [9:0] SCALE_MUL = 10'd780;

  typedef enum logic [1:0] {
    OP_DRAW   = 2'd0,
    OP_MOVE   = 2'd1,
    OP_RESYNC = 2'd2
  } op_t;

  typedef struct packed {
    logic [1:0]         operation;
    logic signed [11:0] x_coord;
    logic signed [11:0] y_coord;
  } point_t;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              last_of_run;
  } code_t;

  // One point's worth of terminal bytes, in send order.
  typedef struct packed {
    logic [MAX_BYTES-1:0][BYTE_W-1:0] bytes;
    logic [IDX_W-1:0]                 last_idx;
  } run_t;

  // (v + 2048) * 780 / 1024; the offset add is a flip of the sign bit.
  function automatic logic [11:0] scale_coord(input logic signed [11:0] v);
    logic [11:0] biased;
    logic [21:0] prod;
    biased = {~v[11], v[10:0]};
    prod   = biased * SCALE_MUL;
    return prod[21:10];
  endfunction

endpackage

[sv/vtae_front.sv]
// Front end: accepts points, scales them, compares with the remembered bytes
// and builds the byte run for each draw or move. Uses vtae_pkg.
`timescale 1ns / 1ps

module vtae_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            point_valid,
  output logic            point_ready,
  input  vtae_pkg::point_t point,
  output logic            push_valid,
  input  logic            push_ready,
  output vtae_pkg::run_t  push_run
);

  logic [4:0] prev_high_y, prev_high_x, prev_low_y;
  logic [3:0] prev_extra;
  logic       remembered_valid;

  logic [11:0] tx, ty;
  logic [4:0]  hix, hiy, lox, loy;
  logic [3:0]  extra;
  logic        is_move, is_plot;
  logic        d_hiy, d_hix, d_extra, d_loy;
  logic [vtae_pkg::IDX_W-1:0] k;
  logic        accept;

  always_comb begin
    case (point.operation)
      vtae_pkg::OP_DRAW: begin
        is_plot = 1'b1;
        is_move = 1'b0;
      end
      vtae_pkg::OP_MOVE: begin
        is_plot = 1'b1;
        is_move = 1'b1;
      end
      default: begin
        is_plot = 1'b0;
        is_move = 1'b0;
      end
    endcase
  end

  assign tx    = vtae_pkg::scale_coord(point.x_coord);
  assign ty    = vtae_pkg::scale_coord(point.y_coord);
  assign hix   = tx[11:7];
  assign hiy   = ty[11:7];
  assign lox   = tx[6:2];
  assign loy   = ty[6:2];
  assign extra = {ty[1:0], tx[1:0]};

  assign d_hiy   = !remembered_valid || (hiy != prev_high_y);
  assign d_hix   = !remembered_valid || (hix != prev_high_x);
  assign d_extra = !remembered_valid || (extra != prev_extra);
  assign d_loy   = !remembered_valid || (loy != prev_low_y);

  always_comb begin
    push_run = '0;
    k        = '0;
    if (is_move) begin
      push_run.bytes[k] = vtae_pkg::BYTE_GS;
      k = k + 1'b1;
    end
    if (d_hiy) begin
      push_run.bytes[k] = {2'b00, hiy} | vtae_pkg::TAG_HIGH;
      k = k + 1'b1;
    end
    if (d_hix) begin
      if (d_extra) begin
        push_run.bytes[k] = {3'b000, extra} | vtae_pkg::TAG_LOWY;
        k = k + 1'b1;
      end
      push_run.bytes[k] = {2'b00, loy} | vtae_pkg::TAG_LOWY;
      k = k + 1'b1;
      push_run.bytes[k] = {2'b00, hix} | vtae_pkg::TAG_HIGH;
      k = k + 1'b1;
    end else if (d_extra) begin
      push_run.bytes[k] = {3'b000, extra} | vtae_pkg::TAG_LOWY;
      k = k + 1'b1;
      push_run.bytes[k] = {2'b00, loy} | vtae_pkg::TAG_LOWY;
      k = k + 1'b1;
    end else if (d_loy) begin
      push_run.bytes[k] = {2'b00, loy} | vtae_pkg::TAG_LOWY;
      k = k + 1'b1;
    end
    push_run.bytes[k] = {2'b00, lox} | vtae_pkg::TAG_LOWX;
    push_run.last_idx = k;
  end

  // Resync goes through without a queue slot, but waits with the rest.
  assign point_ready = push_ready;
  assign push_valid  = point_valid && is_plot;
  assign accept      = point_valid && point_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      remembered_valid <= 1'b0;
      prev_high_y      <= '0;
      prev_high_x      <= '0;
      prev_low_y       <= '0;
      prev_extra       <= '0;
    end else if (accept) begin
      remembered_valid <= is_plot;
      if (is_plot) begin
        prev_high_y <= hiy;
        prev_high_x <= hix;
        prev_low_y  <= loy;
        prev_extra  <= extra;
      end
    end
  end

endmodule

[sv/vtae_queue.sv]
// Small FIFO of byte runs between the front end and the serializer.
// Uses vtae_pkg for the run type.
`timescale 1ns / 1ps

module vtae_queue #(
  parameter int Depth = vtae_pkg::QUEUE_DEPTH
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push_valid,
  output logic           push_ready,
  input  vtae_pkg::run_t push_run,
  output logic           pop_valid,
  input  logic           pop_ready,
  output vtae_pkg::run_t pop_run
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  vtae_pkg::run_t mem [Depth];
  logic [PtrW-1:0] wr_ptr, rd_ptr;
  logic [CntW-1:0] count;
  logic            do_push, do_pop;

  assign push_ready = (count != CntW'(Depth));
  assign pop_valid  = (count != '0);
  assign pop_run    = mem[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_run;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PtrW'(Depth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PtrW'(Depth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

[sv/vtae_back.sv]
// Serializer: walks the queued run one byte a cycle into the output register while code_ready lets it.
// Uses vtae_pkg for the run and code types.
`timescale 1ns / 1ps

module vtae_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            pop_valid,
  output logic            pop_ready,
  input  vtae_pkg::run_t  pop_run,
  output logic            code_valid,
  input  logic            code_ready,
  output vtae_pkg::code_t code
);

  logic [vtae_pkg::IDX_W-1:0] idx;
  logic out_free, load, at_last;

  assign out_free  = !code_valid || code_ready;
  assign load      = out_free && pop_valid;
  assign at_last   = (idx == pop_run.last_idx);
  assign pop_ready = out_free && at_last;

  always_ff @(posedge clk) begin
    if (load) begin
      code.out_byte    <= pop_run.bytes[idx];
      code.last_of_run <= at_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      code_valid <= 1'b0;
      idx        <= '0;
    end else if (load) begin
      code_valid <= 1'b1;
      idx        <= at_last ? '0 : idx + 1'b1;
    end else if (code_ready) begin
      code_valid <= 1'b0;
    end
  end

endmodule

[sv/vector_terminal_address_encoder.sv]
// Vector terminal address encoder, 12-bit plot-mode addressing.
// A point's run is stored in the queue, then fed to the output register.
// Throughput: one byte per cycle out of the serializer while code_ready allows;
//   a point sends 1 to 6 bytes and a resync is accepted but emits nothing.
// Reset: rst (sync, high) empties the queue and output and forgets the
//   remembered bytes, so the next point sends every field.
// Depends on vtae_pkg, vtae_front, vtae_queue, vtae_back.
`timescale 1ns / 1ps

module vector_terminal_address_encoder #(
  parameter int QueueDepth = vtae_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  // point transactions in
  input  logic             point_valid,
  output logic             point_ready,
  input  vtae_pkg::point_t point,
  // terminal byte transactions out
  output logic             code_valid,
  input  logic             code_ready,
  output vtae_pkg::code_t  code
);

  // Front end classifies each point and builds its complete byte run; the
  // remembered high/extra/low-y state lives there so it updates in point order.
  logic           push_valid, push_ready;
  vtae_pkg::run_t push_run;

  // Queue decouples intake from the byte-serial output; while the serializer
  // drains one run the front end can keep accepting into free slots.
  logic           pop_valid, pop_ready;
  vtae_pkg::run_t pop_run;

  vtae_front u_front (
    .clk         (clk),
    .rst         (rst),
    .point_valid (point_valid),
    .point_ready (point_ready),
    .point       (point),
    .push_valid  (push_valid),
    .push_ready  (push_ready),
    .push_run    (push_run)
  );

  vtae_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_run   (push_run),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_run    (pop_run)
  );

  // Back end: registered output, last_of_run flags the final byte of a run.
  vtae_back u_back (
    .clk        (clk),
    .rst        (rst),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_run    (pop_run),
    .code_valid (code_valid),
    .code_ready (code_ready),
    .code       (code)
  );

endmodule
